@@ rtl/pfa_pkg.sv @@
// Shared constants and operation codes for the prime field ALU.
`default_nettype none
package pfa_pkg;
   localparam longint unsigned PFA_MODULUS = 64'd1000000007;
   localparam int IN_W = 30;
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;
endpackage
`default_nettype wire

@@ rtl/pfa_modmul.sv @@
// Four-stage Barrett modular multiplier with a passthrough tag.
`default_nettype none
module pfa_modmul import pfa_pkg::*; #(
   parameter longint unsigned MODULUS = PFA_MODULUS,
   parameter int TAG_W = 1,
   localparam int RW = $clog2(MODULUS + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [RW-1:0]    in_a,
   input  wire logic [RW-1:0]    in_b,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [RW-1:0]         out_prod,
   output logic [TAG_W-1:0]      out_tag
);
   localparam logic [63:0] MOD64 = 64'(MODULUS);
   localparam logic [63:0] MU64  = (64'd1 << (2 * RW)) / MOD64;
   localparam logic [63:0] M2_64 = MOD64 << 1;
   // mu reaches 2^(RW+1) when the modulus is a power of two
   localparam logic [RW+1:0] MU_C = MU64[RW+1:0];
   localparam logic [RW+1:0] M_C  = MOD64[RW+1:0];
   localparam logic [RW+1:0] M2_C = M2_64[RW+1:0];

   logic [2*RW-1:0] p1_ff, p1_in;
   logic [2*RW+1:0] t2_ff, t2_in;
   logic [RW+1:0]   p2_ff, p3_ff, qm3_ff, qm3_in;
   logic [RW-1:0]   r4_ff, r4_in;
   logic [RW+1:0]   diff;
   logic [TAG_W-1:0] g1_ff, g2_ff, g3_ff, g4_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign p1_in  = (2*RW)'(in_a) * (2*RW)'(in_b);
   assign t2_in  = (2*RW+2)'(p1_ff[2*RW-1:RW-1]) * (2*RW+2)'(MU_C);
   // quotient estimate; only low bits of q*m matter since remainder < 3m
   assign qm3_in = (RW+2)'(t2_ff[2*RW+1:RW+1]) * M_C;
   assign diff   = p3_ff - qm3_ff;

   always_comb begin
      if (diff >= M2_C) begin
         r4_in = RW'(diff - M2_C);
      end else if (diff >= M_C) begin
         r4_in = RW'(diff - M_C);
      end else begin
         r4_in = RW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= p1_in;
         t2_ff  <= t2_in;
         p2_ff  <= p1_ff[RW+1:0];
         qm3_ff <= qm3_in;
         p3_ff  <= p2_ff;
         r4_ff  <= r4_in;
         g1_ff  <= in_tag;
         g2_ff  <= g1_ff;
         g3_ff  <= g2_ff;
         g4_ff  <= g3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_prod  = r4_ff;
   assign out_tag   = g4_ff;
endmodule
`default_nettype wire

@@ rtl/pfa_cell.sv @@
// One exponent-bit cell of the square-and-multiply chain.
`default_nettype none
module pfa_cell import pfa_pkg::*; #(
   parameter longint unsigned MODULUS = PFA_MODULUS,
   parameter bit BIT_SET = 1'b1,
   parameter int SIDE_W = 1,
   localparam int RW = $clog2(MODULUS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [RW-1:0]     in_acc,
   input  wire logic [RW-1:0]     in_base,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [RW-1:0]          out_acc,
   output logic [RW-1:0]          out_base,
   output logic [SIDE_W-1:0]      out_side
);
   logic sq_valid, mul_valid;
   logic [RW-1:0] mul_prod, acc_pass;

   pfa_modmul #(.MODULUS(MODULUS), .TAG_W(SIDE_W)) u_square (
      .clock, .reset, .en,
      .in_valid, .in_a(in_base), .in_b(in_base), .in_tag(in_side),
      .out_valid(sq_valid), .out_prod(out_base), .out_tag(out_side)
   );

   pfa_modmul #(.MODULUS(MODULUS), .TAG_W(RW)) u_mult (
      .clock, .reset, .en,
      .in_valid, .in_a(in_acc), .in_b(in_base), .in_tag(in_acc),
      .out_valid(mul_valid), .out_prod(mul_prod), .out_tag(acc_pass)
   );

   assign out_valid = sq_valid & mul_valid;
   assign out_acc   = BIT_SET ? mul_prod : acc_pass;
endmodule
`default_nettype wire

@@ rtl/prime_field_alu.sv @@
// Pipeline: operand reduction registers, a side/base register, one exponent
// cell per bit of MODULUS-2, the final multiplier and the output register.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: synchronous, active high; clears all valid bits, no payload state.
`default_nettype none
module prime_field_alu import pfa_pkg::*; #(
   parameter longint unsigned MODULUS = PFA_MODULUS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [OP_W-1:0] req_op,
   input  wire logic [IN_W-1:0] req_operand_a,
   input  wire logic [IN_W-1:0] req_operand_b,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [IN_W-1:0]      rsp_field_result
);
   localparam int RW     = $clog2(MODULUS + 1);
   localparam int PW     = 2 * IN_W + 2;
   localparam int K      = IN_W + RW;
   localparam logic [63:0] MOD64  = 64'(MODULUS);
   localparam logic [63:0] MUA64  = ((64'd1 << K) + MOD64 - 64'd1) / MOD64;
   localparam logic [63:0] EXPO   = MOD64 - 64'd2;
   localparam int EB     = $clog2(EXPO + 64'd1);
   localparam int SIDE_W = OP_W + 3 * RW;
   localparam int FTAG_W = OP_W + RW;
   localparam logic [PW-1:0] MUA_C = PW'(MUA64);
   localparam logic [IN_W-1:0] M_IN = IN_W'(MOD64);
   localparam logic [RW:0] M_C = MOD64[RW:0];

   logic en;
   logic v1_ff, v2_ff, v3_ff, vp_ff;
   logic [OP_W-1:0] op1_ff, op2_ff, op3_ff;
   logic [IN_W-1:0] xa1_ff, xb1_ff, xa2_ff, xb2_ff;
   logic [PW-1:0]   pa1_ff, pb1_ff;
   logic [IN_W-1:0] qma2_ff, qmb2_ff, qma2_in, qmb2_in;
   logic [RW-1:0]   a3_ff, b3_ff;
   logic [RW:0]     sum, dif;
   logic [RW-1:0]   arith_in;
   logic [SIDE_W-1:0] side_ff;
   logic [RW-1:0]   base_ff;

   logic              val_c  [EB+1];
   logic [RW-1:0]     acc_c  [EB+1];
   logic [RW-1:0]     base_c [EB+1];
   logic [SIDE_W-1:0] side_c [EB+1];

   logic [OP_W-1:0] cop;
   logic [RW-1:0]   ca, cb, carith;
   logic            f_valid;
   logic [RW-1:0]   f_prod;
   logic [FTAG_W-1:0] f_tag;
   logic [OP_W-1:0] f_op;
   logic [RW-1:0]   f_arith;
   logic            rsp_valid_ff;
   logic [IN_W-1:0] rsp_result_ff, rsp_result_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // operand reduction: exact floor(x/m) by reciprocal multiply
   assign qma2_in = IN_W'(IN_W'(pa1_ff >> K) * M_IN);
   assign qmb2_in = IN_W'(IN_W'(pb1_ff >> K) * M_IN);

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff  <= req_op;
         xa1_ff  <= req_operand_a;
         xb1_ff  <= req_operand_b;
         pa1_ff  <= PW'(req_operand_a) * MUA_C;
         pb1_ff  <= PW'(req_operand_b) * MUA_C;
         op2_ff  <= op1_ff;
         xa2_ff  <= xa1_ff;
         xb2_ff  <= xb1_ff;
         qma2_ff <= qma2_in;
         qmb2_ff <= qmb2_in;
         op3_ff  <= op2_ff;
         a3_ff   <= RW'(xa2_ff - qma2_ff);
         b3_ff   <= RW'(xb2_ff - qmb2_ff);
         side_ff <= {op3_ff, a3_ff, b3_ff, arith_in};
         base_ff <= b3_ff;
      end
   end

   assign sum = (RW+1)'(a3_ff) + (RW+1)'(b3_ff);
   assign dif = (a3_ff >= b3_ff) ? (RW+1)'(a3_ff - b3_ff)
                                 : (RW+1)'(a3_ff) + M_C - (RW+1)'(b3_ff);

   always_comb begin
      if (op3_ff == OP_SUB) begin
         arith_in = RW'(dif);
      end else if (sum >= M_C) begin
         arith_in = RW'(sum - M_C);
      end else begin
         arith_in = RW'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vp_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vp_ff <= v3_ff;
      end
   end

   assign val_c[0]  = vp_ff;
   assign acc_c[0]  = RW'(1);
   assign base_c[0] = base_ff;
   assign side_c[0] = side_ff;

   // one cell per bit of the exponent, least significant first
   for (genvar i = 0; i < EB; i++) begin : g_cell
      pfa_cell #(.MODULUS(MODULUS), .BIT_SET(EXPO[i]), .SIDE_W(SIDE_W)) u_cell (
         .clock, .reset, .en,
         .in_valid(val_c[i]), .in_acc(acc_c[i]), .in_base(base_c[i]),
         .in_side(side_c[i]),
         .out_valid(val_c[i+1]), .out_acc(acc_c[i+1]), .out_base(base_c[i+1]),
         .out_side(side_c[i+1])
      );
   end

   assign {cop, ca, cb, carith} = side_c[EB];

   pfa_modmul #(.MODULUS(MODULUS), .TAG_W(FTAG_W)) u_final (
      .clock, .reset, .en,
      .in_valid(val_c[EB]), .in_a(ca),
      .in_b((cop == OP_DIV) ? acc_c[EB] : cb),
      .in_tag({cop, carith}),
      .out_valid(f_valid), .out_prod(f_prod), .out_tag(f_tag)
   );

   assign {f_op, f_arith} = f_tag;
   assign rsp_result_in = (f_op == OP_MUL || f_op == OP_DIV) ? IN_W'(f_prod)
                                                             : IN_W'(f_arith);

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_result = rsp_result_ff;

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (RW + 1)'(a3_ff) < M_C && (RW + 1)'(b3_ff) < M_C)
      else $error("operand reduction out of range");
   a_arith: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (RW + 1)'(arith_in) < M_C)
      else $error("add/sub result out of range");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule
`default_nettype wire
